FILE: hdl/ttint_pkg.sv
// Shared types and constants of the thermistor table interpolator.
package ttint_pkg;

    localparam int RES_W   = 24;
    localparam int TEMP_W  = 16;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int ENTRY_W = RES_W + TEMP_W;

    // Number of quotient bits; the quotient magnitude never reaches 2**16
    localparam int QUO_W = 16;
    localparam int STEP_W = 4;

    typedef enum logic
    {
        ACT_LOAD    = 1'b0,
        ACT_CONVERT = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        ST_OK    = 3'd0,
        ST_ABOVE = 3'd1,
        ST_BELOW = 3'd2,
        ST_EMPTY = 3'd3,
        ST_EQUAL = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIX,
        S_EMIT
    } state_t;

endpackage

FILE: hdl/ttint_ram.sv
// Generic single write port RAM with one registered read port.
module ttint_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word and register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/thermistor_table_interpolator_core.sv
// Top level of the thermistor table interpolator: table RAM, scan sequencer and divider.
//
// Converts a thermistor resistance to a temperature through a breakpoint
// table held in a single-port-read RAM, sorted by falling resistance. A load
// word writes one breakpoint. A convert word walks the table one entry a
// cycle through the RAM read port until it meets the first breakpoint at or
// below the sample, then interpolates with one 16x24 multiply and a 16-step
// restoring divider that yields one quotient bit a cycle; a sample outside
// the table is clamped to the end entry instead. The input channel stalls
// while a conversion is in progress; a finished result sits in an output
// register so the next word can be taken meanwhile. The table has no reset:
// every breakpoint reached by a search must be loaded first. cfg_wr_data
// sets how many breakpoints are in use, capped at TABLE_DEPTH.
module thermistor_table_interpolator_core
    import ttint_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [COUNT_W-1:0]       cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic [INDEX_W-1:0]       entry_index,
    input  logic [RES_W-1:0]         entry_resistance,
    input  logic signed [TEMP_W-1:0] entry_temperature,
    input  logic [RES_W-1:0]         sample_resistance,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temperature,
    output logic [2:0]               status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       entries_reg;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [RES_W-1:0]         sample_reg, sample_next;
    logic [RES_W-1:0]         prev_r_reg, prev_r_next;
    logic [TEMP_W-1:0]        prev_t_reg, prev_t_next;
    logic [RES_W-1:0]         d_reg, d_next;
    logic [RES_W-1:0]         num_reg, num_next;
    logic [TEMP_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [RES_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [TEMP_W-1:0]        res_t_reg, res_t_next;
    status_t                  res_s_reg, res_s_next;
    logic                     out_valid_reg;
    logic [TEMP_W-1:0]        out_temp_reg;
    status_t                  out_status_reg;

    logic                     in_accept;
    logic                     out_free;
    logic [CW-1:0]            n_val;
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [ENTRY_W-1:0]       ram_rd_data;
    logic [RES_W-1:0]         rd_r;
    logic [TEMP_W-1:0]        rd_t;
    logic                     found;
    logic                     last;
    logic signed [TEMP_W:0]   diff;
    logic [RES_W:0]           trial;
    logic [TEMP_W:0]          q_ext;
    logic [TEMP_W:0]          sum;

    // Handshake and table bounds
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign n_val     = (int'(entries_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                         : CW'(entries_reg);

    // Breakpoint table
    assign ram_wr_en   = in_accept && (action == ACT_LOAD) && (int'(entry_index) < TABLE_DEPTH);
    assign ram_rd_addr = (state_reg == S_SCAN) ? AW'(idx_reg + AW'(1)) : '0;

    ttint_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data ({entry_resistance, entry_temperature}),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_r  = ram_rd_data[ENTRY_W-1:TEMP_W];
    assign rd_t  = ram_rd_data[TEMP_W-1:0];
    assign found = (rd_r <= sample_reg);
    assign last  = ((CW'(idx_reg) + CW'(1)) == n_val);

    // Bracket slope, divider step and final correction
    assign diff  = $signed({rd_t[TEMP_W-1], rd_t}) - $signed({prev_t_reg[TEMP_W-1], prev_t_reg});
    assign trial = {rem_reg, quo_reg[QUO_W-1]} - {1'b0, d_reg};
    assign q_ext = {1'b0, quo_reg};
    assign sum   = {prev_t_reg[TEMP_W-1], prev_t_reg} + (neg_reg ? (~q_ext + 1'b1) : q_ext);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_CONVERT))
                begin
                    state_next = (n_val == '0) ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    if (idx_reg == '0 || prev_r_reg <= rd_r)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if (last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        idx_next    = idx_reg;
        step_next   = step_reg;
        sample_next = sample_reg;
        prev_r_next = prev_r_reg;
        prev_t_next = prev_t_reg;
        d_next      = d_reg;
        num_next    = num_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        res_t_next  = res_t_reg;
        res_s_next  = res_s_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next    = '0;
                sample_next = sample_resistance;
                res_t_next  = '0;
                res_s_next  = ST_EMPTY;
            end
            S_SCAN:
            begin
                if (found)
                begin
                    if (idx_reg == '0)
                    begin
                        res_t_next = rd_t;
                        res_s_next = (rd_r == sample_reg) ? ST_OK : ST_ABOVE;
                    end
                    else if (prev_r_reg <= rd_r)
                    begin
                        res_t_next = prev_t_reg;
                        res_s_next = ST_EQUAL;
                    end
                    else
                    begin
                        d_next     = prev_r_reg - rd_r;
                        num_next   = prev_r_reg - sample_reg;
                        neg_next   = diff[TEMP_W];
                        mag_next   = diff[TEMP_W] ? TEMP_W'(-diff) : TEMP_W'(diff);
                        res_s_next = ST_OK;
                    end
                end
                else if (last)
                begin
                    res_t_next = rd_t;
                    res_s_next = ST_BELOW;
                end
                else
                begin
                    prev_r_next = rd_r;
                    prev_t_next = rd_t;
                    idx_next    = idx_reg + AW'(1);
                end
            end
            S_MUL:
            begin
                {rem_next, quo_next} = mag_reg * num_reg;
                step_next            = STEP_W'(QUO_W - 1);
            end
            S_DIV:
            begin
                if (!trial[RES_W])
                begin
                    rem_next = trial[RES_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[RES_W-2:0], quo_reg[QUO_W-1]};
                end
                quo_next  = {quo_reg[QUO_W-2:0], !trial[RES_W]};
                step_next = step_reg - STEP_W'(1);
            end
            S_FIX:
            begin
                res_t_next = sum[TEMP_W-1:0];
            end
            S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prev_r_reg <= prev_r_next;
        prev_t_reg <= prev_t_next;
        d_reg      <= d_next;
        num_reg    <= num_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        res_t_reg  <= res_t_next;
        res_s_reg  <= res_s_next;
        if (state_reg == S_EMIT && out_free)
        begin
            out_temp_reg   <= res_t_reg;
            out_status_reg <= res_s_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = out_temp_reg;
    assign status      = out_status_reg;

    // Divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg != '0))
        else $error("divider running with zero divisor");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < d_reg))
        else $error("divider remainder out of range");

    // Scan never walks past the entries in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((CW'(idx_reg) + CW'(1)) <= n_val))
        else $error("table scan beyond entries in use");

    // A result handed over appears on the output next cycle
    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result lost on hand-over");

endmodule
